>>> sv/mmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mmc_pkg;

    localparam int WINDOW_LEN_DEF  = 5;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int FIELD_BITS      = 24;
    // 100 * 256, the scale of one normalized unit in 1/256 steps
    localparam int NORM_SCALE_FRAC = 25600;
    localparam int SCALE_BITS      = 15;

    localparam int NUM_AXES        = 3;

    localparam int NUM_CAL_REGS    = 6;
    localparam int CAL_IDX_BITS    = 3;
    localparam int PADDR_BITS      = 5;
    localparam int PDATA_BITS      = 32;

    typedef logic [CAL_IDX_BITS-1:0] cal_idx_t;

    localparam cal_idx_t REG_X_LOW  = 3'd0;
    localparam cal_idx_t REG_X_HIGH = 3'd1;
    localparam cal_idx_t REG_Y_LOW  = 3'd2;
    localparam cal_idx_t REG_Y_HIGH = 3'd3;
    localparam cal_idx_t REG_Z_LOW  = 3'd4;
    localparam cal_idx_t REG_Z_HIGH = 3'd5;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

endpackage

`default_nettype wire

>>> sv/magnetometer_median_calibrate_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// one reading in flight at a time; a reading without data_ready skips the search and scaling;
// the work per reading is done by the bit-serial divider
// (SAMPLE_BITS+17 steps per axis) and the one-candidate-per-cycle median rank search
// the output register holds a result while the next reading is taken
// reset: windows, held results and window slot cleared, calibration to full scale

module magnetometer_median_calibrate_unit #(
    parameter int WINDOW_LEN  = mmc_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   data_ready,
    input  logic signed [SAMPLE_BITS-1:0]          raw_x,
    input  logic signed [SAMPLE_BITS-1:0]          raw_y,
    input  logic signed [SAMPLE_BITS-1:0]          raw_z,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [mmc_pkg::FIELD_BITS-1:0]  field_x,
    output logic signed [mmc_pkg::FIELD_BITS-1:0]  field_y,
    output logic signed [mmc_pkg::FIELD_BITS-1:0]  field_z,
    output logic signed [SAMPLE_BITS-1:0]          median_x,
    output logic signed [SAMPLE_BITS-1:0]          median_y,
    output logic signed [SAMPLE_BITS-1:0]          median_z,
    output logic                                   fresh,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [mmc_pkg::PADDR_BITS-1:0]         paddr,
    input  logic [mmc_pkg::PDATA_BITS-1:0]         pwdata,
    output logic [mmc_pkg::PDATA_BITS-1:0]         prdata,
    output logic                                   pready
);
    import mmc_pkg::*;

    localparam int IW          = $clog2(WINDOW_LEN);
    localparam int CW          = $clog2(WINDOW_LEN+1);
    localparam int MEDIAN_RANK = WINDOW_LEN / 2;
    localparam int PROD_BITS   = SAMPLE_BITS + 1 + SCALE_BITS;
    localparam int DIV_BITS    = PROD_BITS + 1;

    localparam logic [DIV_BITS-1:0] Q_POS_LIM = DIV_BITS'((1 << (FIELD_BITS-1)) - 1);
    localparam logic [DIV_BITS-1:0] Q_NEG_LIM = DIV_BITS'(1 << (FIELD_BITS-1));

    localparam logic signed [FIELD_BITS-1:0] FIELD_MAX = {1'b0, {(FIELD_BITS-1){1'b1}}};
    localparam logic signed [FIELD_BITS-1:0] FIELD_MIN = {1'b1, {(FIELD_BITS-1){1'b0}}};

    localparam logic signed [SAMPLE_BITS-1:0] CAL_LOW_RST  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] CAL_HIGH_RST = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANK,
        S_SCALE,
        S_MUL,
        S_DIV,
        S_ROUND,
        S_SAT,
        S_DONE
    } state_t;

    // ---------------- configuration ----------------
    logic signed [SAMPLE_BITS-1:0] cal_reg [NUM_CAL_REGS];
    cal_idx_t                      cal_idx;
    logic                          cal_hit;
    logic                          cal_wr;

    assign cal_idx = paddr[PADDR_BITS-1:2];
    assign cal_hit = cal_idx < CAL_IDX_BITS'(NUM_CAL_REGS);
    assign cal_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CAL_REGS; i++)
            begin
                cal_reg[i] <= (i % 2 == 0) ? CAL_LOW_RST : CAL_HIGH_RST;
            end
        end
        else if (cal_wr && cal_hit)
        begin
            cal_reg[cal_idx] <= pwdata[SAMPLE_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cal_hit)
        begin
            prdata = PDATA_BITS'(cal_reg[cal_idx]);
        end
    end

    // ---------------- sequencer and datapath registers ----------------
    state_t                        state_reg;
    axis_t                         axis_reg;
    logic [IW-1:0]                 idx_reg;
    logic [IW-1:0]                 pos_reg;
    logic                          out_valid_reg;
    logic                          div_start_reg;
    logic signed [FIELD_BITS-1:0]  field_held_reg [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] median_held_reg [NUM_AXES];

    logic                          fresh_reg;
    logic signed [SAMPLE_BITS-1:0] med_reg;
    logic [SAMPLE_BITS:0]          absd_reg;
    logic [SAMPLE_BITS-1:0]        divisor_reg;
    logic                          neg_reg;
    logic                          zero_reg;
    logic [DIV_BITS-1:0]           dividend_reg;
    logic [DIV_BITS-1:0]           q_reg;
    logic signed [FIELD_BITS-1:0]  out_field_reg [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] out_median_reg [NUM_AXES];
    logic                          out_fresh_reg;

    logic                          accept;
    logic                          out_take;
    logic                          out_load;
    logic                          median_hit;

    logic signed [SAMPLE_BITS-1:0] rd_value;
    logic [CW-1:0]                 lt_count;
    logic [CW-1:0]                 le_count;

    logic signed [SAMPLE_BITS-1:0] cal_lo;
    logic signed [SAMPLE_BITS-1:0] cal_hi;
    logic signed [SAMPLE_BITS+1:0] num_diff;
    logic signed [SAMPLE_BITS:0]   den_diff;
    logic [SAMPLE_BITS:0]          num_abs;
    logic [SAMPLE_BITS-1:0]        den_abs;
    logic [PROD_BITS-1:0]          prod;
    logic [DIV_BITS:0]             q_sum;
    logic [DIV_BITS-1:0]           quotient;
    logic                          div_done;
    logic signed [FIELD_BITS-1:0]  sat_value;

    assign in_stall   = state_reg != S_IDLE;
    assign accept     = in_valid && !in_stall;
    assign out_take   = out_valid_reg && !out_stall;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign median_hit = (lt_count <= CW'(MEDIAN_RANK)) && (le_count > CW'(MEDIAN_RANK));

    mmc_window #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && data_ready),
        .wr_pos   (pos_reg),
        .wr_x     (raw_x),
        .wr_y     (raw_y),
        .wr_z     (raw_z),
        .rd_axis  (axis_reg),
        .rd_idx   (idx_reg),
        .rd_value (rd_value),
        .lt_count (lt_count),
        .le_count (le_count)
    );

    mmc_divider #(
        .NUM_BITS (DIV_BITS),
        .DEN_BITS (SAMPLE_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                cal_lo = cal_reg[REG_X_LOW];
                cal_hi = cal_reg[REG_X_HIGH];
            end
            AXIS_Y:
            begin
                cal_lo = cal_reg[REG_Y_LOW];
                cal_hi = cal_reg[REG_Y_HIGH];
            end
            default:
            begin
                cal_lo = cal_reg[REG_Z_LOW];
                cal_hi = cal_reg[REG_Z_HIGH];
            end
        endcase
    end

    // 2*m - lo - hi over hi - lo, split into magnitudes and a sign
    assign num_diff = (SAMPLE_BITS+2)'(med_reg) + (SAMPLE_BITS+2)'(med_reg)
                    - (SAMPLE_BITS+2)'(cal_lo) - (SAMPLE_BITS+2)'(cal_hi);
    assign den_diff = (SAMPLE_BITS+1)'(cal_hi) - (SAMPLE_BITS+1)'(cal_lo);
    assign num_abs  = num_diff[SAMPLE_BITS+1] ? (SAMPLE_BITS+1)'(-num_diff)
                                              : (SAMPLE_BITS+1)'(num_diff);
    assign den_abs  = den_diff[SAMPLE_BITS] ? SAMPLE_BITS'(-den_diff) : SAMPLE_BITS'(den_diff);

    assign prod = PROD_BITS'(absd_reg) * PROD_BITS'(NORM_SCALE_FRAC);

    // quotient is floor(2n/d); adding one and halving rounds half away from zero
    assign q_sum = {1'b0, quotient} + (DIV_BITS+1)'(1);

    always_comb
    begin
        priority if (zero_reg)
        begin
            sat_value = '0;
        end
        else if (neg_reg)
        begin
            sat_value = (q_reg > Q_NEG_LIM) ? FIELD_MIN : -$signed(q_reg[FIELD_BITS-1:0]);
        end
        else
        begin
            sat_value = (q_reg > Q_POS_LIM) ? FIELD_MAX : $signed(q_reg[FIELD_BITS-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= AXIS_X;
            idx_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                field_held_reg[a]  <= '0;
                median_held_reg[a] <= '0;
            end
        end
        else
        begin
            div_start_reg <= (state_reg == S_MUL) && !zero_reg;
            // a new result replaces a taken one in the same cycle
            out_valid_reg <= out_load || (out_valid_reg && !out_take);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        axis_reg <= AXIS_X;
                        idx_reg  <= '0;
                        if (data_ready)
                        begin
                            pos_reg   <= (pos_reg == IW'(WINDOW_LEN-1)) ? '0 : pos_reg + 1'b1;
                            state_reg <= S_RANK;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_RANK:
                begin
                    if (median_hit)
                    begin
                        state_reg <= S_SCALE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SCALE:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (zero_reg)
                    begin
                        state_reg <= S_ROUND;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    state_reg <= S_SAT;
                end
                S_SAT:
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        if (axis_reg == axis_t'(a))
                        begin
                            field_held_reg[a]  <= sat_value;
                            median_held_reg[a] <= med_reg;
                        end
                    end
                    if (axis_reg == AXIS_Z)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        axis_reg  <= (axis_reg == AXIS_X) ? AXIS_Y : AXIS_Z;
                        idx_reg   <= '0;
                        state_reg <= S_RANK;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fresh_reg <= data_ready;
        end
        if ((state_reg == S_RANK) && median_hit)
        begin
            med_reg <= rd_value;
        end
        if (state_reg == S_SCALE)
        begin
            absd_reg    <= num_abs;
            divisor_reg <= den_abs;
            neg_reg     <= num_diff[SAMPLE_BITS+1] ^ den_diff[SAMPLE_BITS] ^ (axis_reg != AXIS_Z);
            zero_reg    <= den_diff == '0;
        end
        if (state_reg == S_MUL)
        begin
            dividend_reg <= {prod, 1'b0};
        end
        if (state_reg == S_ROUND)
        begin
            q_reg <= q_sum[DIV_BITS:1];
        end
        if (out_load)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                out_field_reg[a]  <= field_held_reg[a];
                out_median_reg[a] <= median_held_reg[a];
            end
            out_fresh_reg <= fresh_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign field_x   = out_field_reg[0];
    assign field_y   = out_field_reg[1];
    assign field_z   = out_field_reg[2];
    assign median_x  = out_median_reg[0];
    assign median_y  = out_median_reg[1];
    assign median_z  = out_median_reg[2];
    assign fresh     = out_fresh_reg;

endmodule

`default_nettype wire

>>> sv/mmc_window.sv
`timescale 1ns / 1ps
`default_nettype none

module mmc_window #(
    parameter int WINDOW_LEN  = mmc_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = mmc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [$clog2(WINDOW_LEN)-1:0]        wr_pos,
    input  logic signed [SAMPLE_BITS-1:0]        wr_x,
    input  logic signed [SAMPLE_BITS-1:0]        wr_y,
    input  logic signed [SAMPLE_BITS-1:0]        wr_z,
    input  mmc_pkg::axis_t                       rd_axis,
    input  logic [$clog2(WINDOW_LEN)-1:0]        rd_idx,
    output logic signed [SAMPLE_BITS-1:0]        rd_value,
    output logic [$clog2(WINDOW_LEN+1)-1:0]      lt_count,
    output logic [$clog2(WINDOW_LEN+1)-1:0]      le_count
);
    import mmc_pkg::*;

    localparam int CW = $clog2(WINDOW_LEN+1);

    logic signed [SAMPLE_BITS-1:0] win_reg [NUM_AXES][WINDOW_LEN];
    logic signed [SAMPLE_BITS-1:0] row [WINDOW_LEN];
    logic signed [SAMPLE_BITS-1:0] cand;
    logic [CW-1:0]                 lt_sum;
    logic [CW-1:0]                 le_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                for (int j = 0; j < WINDOW_LEN; j++)
                begin
                    win_reg[a][j] <= '0;
                end
            end
        end
        else if (wr_en)
        begin
            win_reg[0][wr_pos] <= wr_x;
            win_reg[1][wr_pos] <= wr_y;
            win_reg[2][wr_pos] <= wr_z;
        end
    end

    always_comb
    begin
        unique case (rd_axis)
            AXIS_X:  row = win_reg[0];
            AXIS_Y:  row = win_reg[1];
            default: row = win_reg[2];
        endcase
    end

    assign cand = row[rd_idx];

    // rank of the candidate: the median is the entry whose rank range holds the middle slot
    always_comb
    begin
        lt_sum = '0;
        le_sum = '0;
        for (int j = 0; j < WINDOW_LEN; j++)
        begin
            lt_sum = lt_sum + CW'(row[j] <  cand);
            le_sum = le_sum + CW'(row[j] <= cand);
        end
    end

    assign rd_value = cand;
    assign lt_count = lt_sum;
    assign le_count = le_sum;

endmodule

`default_nettype wire

>>> sv/mmc_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module mmc_divider #(
    parameter int NUM_BITS = 33,
    parameter int DEN_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0] divisor,
    output logic [NUM_BITS-1:0] quotient,
    output logic                done
);

    localparam int CNT_BITS = $clog2(NUM_BITS+1);

    logic [NUM_BITS-1:0] quo_reg;
    logic [DEN_BITS-1:0] rem_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   rem_shift;
    logic [DEN_BITS:0]   trial;
    logic                fits;

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[NUM_BITS-1]};
    assign fits      = rem_shift >= {1'b0, divisor};
    assign trial     = rem_shift - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
            rem_reg <= fits ? trial[DEN_BITS-1:0] : rem_shift[DEN_BITS-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mmc_pkg::*;

    localparam int WIN          = WINDOW_LEN_DEF;
    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int SAMPLE_MAX   = (1 << (SB - 1)) - 1;
    localparam int SAMPLE_MIN   = -(1 << (SB - 1));
    localparam longint FIELD_MAX  = (longint'(1) << (FIELD_BITS - 1)) - 1;
    localparam longint FIELD_MIN  = -(longint'(1) << (FIELD_BITS - 1));
    localparam longint FIELD_SPAN = longint'(1) << FIELD_BITS;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 82;
    localparam int END_SETTLE   = 200;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int MAX_REPORTS  = 10;

    typedef logic signed [SB-1:0]         sample_t;
    typedef logic signed [FIELD_BITS-1:0] field_t;

    typedef struct packed {
        logic    ready;
        sample_t x;
        sample_t y;
        sample_t z;
    } reading_t;

    typedef struct packed {
        field_t  fx;
        field_t  fy;
        field_t  fz;
        sample_t mx;
        sample_t my;
        sample_t mz;
        logic    fresh;
    } mag_result_t;

    typedef enum logic {
        ROW_READING,
        ROW_CAL_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        reading_t    rd;
        bit          typed;
        mag_result_t want;
        cal_idx_t    reg_idx;
        int          reg_val;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   data_ready = 1'b0;
    sample_t                raw_x = '0;
    sample_t                raw_y = '0;
    sample_t                raw_z = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    field_t                 field_x;
    field_t                 field_y;
    field_t                 field_z;
    sample_t                median_x;
    sample_t                median_y;
    sample_t                median_z;
    logic                   fresh;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_BITS-1:0]  paddr = '0;
    logic [PDATA_BITS-1:0]  pwdata = '0;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;

    // predictor state
    sample_t     sample_hist [NUM_AXES][WIN];
    int          hist_slot;
    field_t      last_field [NUM_AXES];
    sample_t     last_median [NUM_AXES];
    sample_t     cal_lo [NUM_AXES];
    sample_t     cal_hi [NUM_AXES];
    sample_t     prev_raw [NUM_AXES];

    mag_result_t pending_results [$];
    stim_row_t   stim_rows [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_burst    = 0;
    int cycle_count    = 0;
    int failures       = 0;
    int results_seen   = 0;
    int fresh_seen     = 0;
    int readings_sent  = 0;
    int directed_sent  = 0;

    magnetometer_median_calibrate_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_ready (data_ready),
        .raw_x      (raw_x),
        .raw_y      (raw_y),
        .raw_z      (raw_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .field_x    (field_x),
        .field_y    (field_y),
        .field_z    (field_z),
        .median_x   (median_x),
        .median_y   (median_y),
        .median_z   (median_z),
        .fresh      (fresh),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver back-pressure, with an occasional long burst
    always @(posedge clk)
    begin
        if (stall_burst > 0)
        begin
            stall_burst--;
            out_stall <= 1'b1;
        end
        else if (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct)
        begin
            out_stall <= 1'b1;
            if ($urandom_range(31) == 0)
                stall_burst = $urandom_range(200, 20);
        end
        else
            out_stall <= 1'b0;
    end

    function automatic field_t scale_axis(longint m, longint lo, longint hi, bit negate);
        longint span;
        longint num;
        longint an;
        longint ad;
        longint q;
        longint r;
        bit     flip;
        span = hi - lo;
        if (span == 0)
            return '0;
        num = (2 * m - lo - hi) * NORM_SCALE_FRAC;
        an = (num < 0) ? -num : num;
        ad = (span < 0) ? -span : span;
        // round half away from zero on the magnitude
        q = (2 * an + ad) / (2 * ad);
        if (q > FIELD_SPAN)
            q = FIELD_SPAN;
        flip = ((num < 0) != (span < 0)) != negate;
        r = flip ? -q : q;
        if (r > FIELD_MAX)
            r = FIELD_MAX;
        if (r < FIELD_MIN)
            r = FIELD_MIN;
        return field_t'(r);
    endfunction

    function automatic mag_result_t filter_and_scale(reading_t rd);
        sample_t     raw [NUM_AXES];
        int          sorted [WIN];
        int          a;
        int          k;
        int          j;
        int          key;
        mag_result_t res;
        raw[AXIS_X] = rd.x;
        raw[AXIS_Y] = rd.y;
        raw[AXIS_Z] = rd.z;
        if (rd.ready)
        begin
            for (a = 0; a < NUM_AXES; a++)
            begin
                sample_hist[a][hist_slot] = raw[a];
                for (k = 0; k < WIN; k++)
                    sorted[k] = sample_hist[a][k];
                for (k = 1; k < WIN; k++)
                begin
                    key = sorted[k];
                    j = k - 1;
                    while (j >= 0 && sorted[j] > key)
                    begin
                        sorted[j + 1] = sorted[j];
                        j--;
                    end
                    sorted[j + 1] = key;
                end
                last_median[a] = sample_t'(sorted[WIN / 2]);
                last_field[a]  = scale_axis(sorted[WIN / 2], cal_lo[a], cal_hi[a],
                                            axis_t'(a) != AXIS_Z);
            end
            hist_slot = (hist_slot + 1 >= WIN) ? 0 : hist_slot + 1;
        end
        res.fx    = last_field[AXIS_X];
        res.fy    = last_field[AXIS_Y];
        res.fz    = last_field[AXIS_Z];
        res.mx    = last_median[AXIS_X];
        res.my    = last_median[AXIS_Y];
        res.mz    = last_median[AXIS_Z];
        res.fresh = rd.ready;
        return res;
    endfunction

    function automatic sample_t pick_raw(int axis);
        int c;
        int h;
        int v;
        c = (int'(cal_lo[axis]) + int'(cal_hi[axis])) / 2;
        h = int'(cal_hi[axis]) - int'(cal_lo[axis]);
        if (h < 0)
            h = -h;
        h = h / 2 + 2;
        case ($urandom_range(9))
            0:       v = SAMPLE_MAX;
            1:       v = SAMPLE_MIN;
            2, 3, 4: v = int'(sample_t'($urandom()));
            5, 6, 7: v = c - h + int'($urandom_range(2 * h));
            8:       v = prev_raw[axis];
            default: v = int'($urandom_range(16)) - 8;
        endcase
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        if (v < SAMPLE_MIN)
            v = SAMPLE_MIN;
        prev_raw[axis] = sample_t'(v);
        return sample_t'(v);
    endfunction

    function automatic reading_t random_reading();
        reading_t rd;
        rd.ready = ($urandom_range(99) < 80);
        rd.x     = pick_raw(AXIS_X);
        rd.y     = pick_raw(AXIS_Y);
        rd.z     = pick_raw(AXIS_Z);
        return rd;
    endfunction

    function automatic void add_reading(logic dr, int x, int y, int z, bit zero_result);
        stim_row_t row;
        row.kind       = ROW_READING;
        row.rd         = {dr, sample_t'(x), sample_t'(y), sample_t'(z)};
        row.typed      = zero_result;
        row.want       = '0;
        row.want.fresh = dr;
        row.reg_idx    = REG_X_LOW;
        row.reg_val    = 0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cal_write(cal_idx_t idx, int value);
        stim_row_t row;
        row.kind    = ROW_CAL_WRITE;
        row.rd      = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        row.reg_idx = idx;
        row.reg_val = value;
        stim_rows.push_back(row);
    endfunction

    task automatic send_reading(reading_t rd, bit typed, mag_result_t typed_want);
        int          gap;
        mag_result_t want;
        gap = 0;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            gap = $urandom_range(100, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_ready <= rd.ready;
        raw_x      <= rd.x;
        raw_y      <= rd.y;
        raw_z      <= rd.z;
        do
            @(posedge clk);
        while (in_stall);
        want = filter_and_scale(rd);
        pending_results.push_back(typed ? typed_want : want);
        readings_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cal(cal_idx_t idx, int value);
        logic [PDATA_BITS-SB-1:0] junk;
        junk = (PDATA_BITS-SB)'($urandom());
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'({idx, 2'b00});
        pwdata  <= {junk, sample_t'(value)};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // upper data bits are dropped, indexes past the last register do nothing
        case (idx)
            REG_X_LOW:  cal_lo[AXIS_X] = sample_t'(value);
            REG_X_HIGH: cal_hi[AXIS_X] = sample_t'(value);
            REG_Y_LOW:  cal_lo[AXIS_Y] = sample_t'(value);
            REG_Y_HIGH: cal_hi[AXIS_Y] = sample_t'(value);
            REG_Z_LOW:  cal_lo[AXIS_Z] = sample_t'(value);
            REG_Z_HIGH: cal_hi[AXIS_Z] = sample_t'(value);
            default: ;
        endcase
    endtask

    task automatic load_calibration(int phase);
        int a;
        int lo;
        int hi;
        int c;
        int d;
        for (a = 0; a < NUM_AXES; a++)
        begin
            case (phase)
                0:
                begin
                    lo = SAMPLE_MIN;
                    hi = SAMPLE_MAX;
                end
                1:
                begin
                    lo = SAMPLE_MAX;
                    hi = SAMPLE_MIN;
                end
                2:
                begin
                    lo = -int'($urandom_range(32768));
                    hi = int'($urandom_range(32767));
                end
                3:
                begin
                    // narrow spans drive most results into saturation
                    c  = int'($urandom_range(40000)) - 20000;
                    d  = $urandom_range(300);
                    lo = c - d;
                    hi = c + d;
                end
                4:
                begin
                    // span of 4096 puts exact halves on odd medians
                    lo = -2048;
                    hi = 2048;
                    if (axis_t'(a) == AXIS_Y)
                    begin
                        lo = int'(sample_t'($urandom()));
                        hi = lo;
                    end
                end
                5:
                begin
                    lo = int'(sample_t'($urandom()));
                    hi = int'(sample_t'($urandom()));
                end
                6:
                begin
                    lo = -int'($urandom_range(600, 200));
                    hi = int'($urandom_range(600, 200));
                    if (axis_t'(a) == AXIS_X)
                    begin
                        c  = lo;
                        lo = hi;
                        hi = c;
                    end
                    if (axis_t'(a) == AXIS_Z)
                    begin
                        lo = int'(sample_t'($urandom()));
                        hi = lo;
                    end
                end
                default:
                begin
                    lo = -int'($urandom_range(600, 200));
                    hi = int'($urandom_range(600, 200));
                end
            endcase
            case (axis_t'(a))
                AXIS_X:
                begin
                    write_cal(REG_X_LOW, lo);
                    write_cal(REG_X_HIGH, hi);
                end
                AXIS_Y:
                begin
                    write_cal(REG_Y_LOW, lo);
                    write_cal(REG_Y_HIGH, hi);
                end
                default:
                begin
                    write_cal(REG_Z_LOW, lo);
                    write_cal(REG_Z_HIGH, hi);
                end
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        mag_result_t got;
        mag_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {field_x, field_y, field_z, median_x, median_y, median_z, fresh};
            results_seen++;
            if (got.fresh)
                fresh_seen++;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("beat %0d: result with no reading pending", results_seen);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                    begin
                        $display("beat %0d: want fx=%0d fy=%0d fz=%0d mx=%0d my=%0d mz=%0d f=%0b",
                                 results_seen, $signed(want.fx), $signed(want.fy),
                                 $signed(want.fz), $signed(want.mx), $signed(want.my),
                                 $signed(want.mz), want.fresh);
                        $display("beat %0d: got  fx=%0d fy=%0d fz=%0d mx=%0d my=%0d mz=%0d f=%0b",
                                 results_seen, $signed(got.fx), $signed(got.fy),
                                 $signed(got.fz), $signed(got.mx), $signed(got.my),
                                 $signed(got.mz), got.fresh);
                    end
                end
            end
        end
    end

    initial
    begin
        int a;
        int k;
        int p;
        int n;
        for (a = 0; a < NUM_AXES; a++)
        begin
            for (k = 0; k < WIN; k++)
                sample_hist[a][k] = '0;
            last_field[a]  = '0;
            last_median[a] = '0;
            cal_lo[a]      = sample_t'(SAMPLE_MIN);
            cal_hi[a]      = sample_t'(SAMPLE_MAX);
            prev_raw[a]    = '0;
        end
        hist_slot = 0;

        // held zeros after reset, then the zero-filled window masks the first extremes
        add_reading(1'b0, 7, -7, 1234, 1'b1);
        add_reading(1'b1, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        add_reading(1'b1, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        add_reading(1'b0, -1, -1, -1, 1'b1);
        add_reading(1'b1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        add_reading(1'b1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        add_reading(1'b0, 0, 0, 0, 1'b0);
        add_reading(1'b1, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        add_reading(1'b1, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        // zero span on x, inverted y, one-count span on z, write past the last register
        add_cal_write(REG_X_LOW, 100);
        add_cal_write(REG_X_HIGH, 100);
        add_cal_write(REG_Y_LOW, 1000);
        add_cal_write(REG_Y_HIGH, -1000);
        add_cal_write(REG_Z_LOW, 0);
        add_cal_write(REG_Z_HIGH, 1);
        add_cal_write(cal_idx_t'(NUM_CAL_REGS), 77);
        add_reading(1'b1, 5, 5, SAMPLE_MAX, 1'b0);
        add_reading(1'b1, 5, 5, SAMPLE_MAX, 1'b0);
        add_reading(1'b1, -5, -5, SAMPLE_MIN, 1'b0);
        add_reading(1'b0, 123, -456, 789, 1'b0);
        // ties on x and z, x/y negation ahead of the clamp
        add_cal_write(REG_X_LOW, -2048);
        add_cal_write(REG_X_HIGH, 2048);
        add_cal_write(REG_Y_HIGH, 1);
        add_cal_write(REG_Y_LOW, 0);
        add_cal_write(REG_Z_LOW, -2048);
        add_cal_write(REG_Z_HIGH, 2048);
        add_reading(1'b1, 1, SAMPLE_MIN, -1, 1'b0);
        add_reading(1'b1, 1, SAMPLE_MIN, -1, 1'b0);
        add_reading(1'b1, 1, SAMPLE_MIN, -1, 1'b0);
        add_reading(1'b1, -1, SAMPLE_MAX, 3, 1'b0);
        add_reading(1'b1, -1, SAMPLE_MAX, 3, 1'b0);
        add_reading(1'b1, -1, SAMPLE_MAX, 3, 1'b0);
        add_reading(1'b0, SAMPLE_MIN, SAMPLE_MAX, 0, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[k])
        begin
            if (stim_rows[k].kind == ROW_CAL_WRITE)
            begin
                wait_idle();
                write_cal(stim_rows[k].reg_idx, stim_rows[k].reg_val);
            end
            else
                send_reading(stim_rows[k].rd, stim_rows[k].typed, stim_rows[k].want);
        end
        directed_sent = readings_sent;

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            load_calibration(p);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 66;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 66;
                end
                default:
                begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 10;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_reading(random_reading(), 1'b0, '0);
        end

        wait_idle();
        recv_stall_pct = 0;
        repeat (END_SETTLE) @(posedge clk);

        $display("%0d readings (%0d directed) gave %0d beats, %0d fresh and %0d held",
                 readings_sent, directed_sent, results_seen, fresh_seen,
                 results_seen - fresh_seen);
        $display("%0d calibration phases: full scale, inverted, narrow, ties, zero span; %0d bad",
                 NUM_PHASES, failures);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
